// ----- rtl/core/moving_average_rise_reporter_unit_assert.svh -----
// assertion macros used by mar_report of the moving average rise reporter rtl
`ifndef MOVING_AVERAGE_RISE_REPORTER_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_RISE_REPORTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define MAR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define MAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MAR_ASSERT_NOW(label, ante, cons)
`define MAR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/mar_pkg.sv -----
// types, constants and sizing for the moving average rise reporter
`timescale 1ns / 1ps

package mar_pkg;

    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 12;

    localparam int ADC_BITS       = 12;
    localparam int MEAN_BITS      = 20;
    localparam int THRESH_BITS    = 20;
    localparam int LIMIT_BITS     = 8;
    localparam int QUIET_BITS     = 9;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int FRAC_BITS      = 8;

    localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = {MEAN_BITS{1'b1}};
    localparam logic [QUIET_BITS-1:0] QUIET_MAX = {QUIET_BITS{1'b1}};

    localparam logic [THRESH_BITS-1:0] RISE_THRESHOLD_RESET = 20'd351;
    localparam logic [LIMIT_BITS-1:0]  QUIET_LIMIT_RESET    = 8'd4;

    // running sum of the window
    localparam int SUM_BITS    = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);
    // sum scaled by 256 before the divide
    localparam int SCALED_BITS = SUM_BITS + FRAC_BITS;
    // reciprocal multiply: exact floor divide by WINDOW over SCALED_BITS
    localparam int RECIP_SHIFT = SCALED_BITS + $clog2(WINDOW);
    localparam int RECIP_BITS  = SCALED_BITS + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam int MEAN_SHIFT  = RECIP_SHIFT - FRAC_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_MULT =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int MEAN_WIDE_BITS =
        (SAMPLE_BITS + FRAC_BITS > MEAN_BITS) ? SAMPLE_BITS + FRAC_BITS : MEAN_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RISE_THRESHOLD = 2'd0,
        REG_QUIET_LIMIT    = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] rise_threshold;
        logic [LIMIT_BITS-1:0]  quiet_limit;
    } mar_cfg_t;

endpackage

// ----- rtl/core/mar_cell.sv -----
// one sample cell of the window shift chain
`timescale 1ns / 1ps

module mar_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shift,
    input  logic [mar_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic [mar_pkg::SAMPLE_BITS-1:0] sample_out
);
    import mar_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;

    // take the neighbour's sample on every accepted transaction
    always_comb
    begin
        sample_next = shift ? sample_in : sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

// ----- rtl/core/mar_window.sv -----
// window of sample cells with the running sum stage
`timescale 1ns / 1ps

module mar_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            accept,
    input  logic [mar_pkg::SAMPLE_BITS-1:0] sample,
    output logic [mar_pkg::SUM_BITS-1:0]    total,
    output logic                            total_valid
);
    import mar_pkg::*;

    logic [SAMPLE_BITS-1:0] chain [WINDOW+1];
    logic [SUM_BITS-1:0]    total_reg;
    logic [SUM_BITS-1:0]    total_next;
    logic                   valid_reg;
    logic                   valid_next;

    assign chain[0] = sample;

    // newest sample enters cell 0, oldest sits in the last cell
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        mar_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .sample_in  (chain[i]),
            .sample_out (chain[i+1])
        );
    end

    always_comb
    begin
        total_next = total_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            total_next = total_reg - SUM_BITS'(chain[WINDOW]) + SUM_BITS'(sample);
        end
        if (advance)
        begin
            valid_next = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    assign total       = total_reg;
    assign total_valid = valid_reg;

endmodule

// ----- rtl/core/mar_report.sv -----
// mean scaling, rise and quiet decision, output register
`timescale 1ns / 1ps

module mar_report (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  mar_pkg::mar_cfg_t             cfg,
    input  logic [mar_pkg::SUM_BITS-1:0]  total,
    input  logic                          total_valid,
    output logic                          stall,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mar_pkg::MEAN_BITS-1:0] mean_value,
    output logic                          forced_report
);
    import mar_pkg::*;

`include "moving_average_rise_reporter_unit_assert.svh"

    logic [PROD_BITS-1:0]      prod_reg;
    logic [PROD_BITS-1:0]      prod_next;
    logic                      prod_valid_reg;
    logic                      prod_valid_next;
    logic [MEAN_BITS-1:0]      reported_mean_reg;
    logic [MEAN_BITS-1:0]      reported_mean_next;
    logic [QUIET_BITS-1:0]     quiet_ticks_reg;
    logic [QUIET_BITS-1:0]     quiet_ticks_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [MEAN_BITS-1:0]      mean_value_reg;
    logic [MEAN_BITS-1:0]      mean_value_next;
    logic                      forced_reg;
    logic                      forced_next;
    logic [MEAN_WIDE_BITS-1:0] mean_wide;
    logic [MEAN_BITS-1:0]      mean;
    logic [QUIET_BITS-1:0]     ticks_inc;
    logic                      rise;
    logic                      quiet;
    logic                      report;
    logic                      decide;

    // scale stage: sum times reciprocal of the window length
    always_comb
    begin
        prod_next       = prod_reg;
        prod_valid_next = prod_valid_reg;
        if (advance)
        begin
            prod_next       = PROD_BITS'(total) * PROD_BITS'(RECIP_MULT);
            prod_valid_next = total_valid;
        end
    end

    // decision stage
    always_comb
    begin
        mean_wide = MEAN_WIDE_BITS'(prod_reg >> MEAN_SHIFT);
        if (mean_wide > MEAN_WIDE_BITS'(MEAN_MAX))
        begin
            mean = MEAN_MAX;
        end
        else
        begin
            mean = MEAN_BITS'(mean_wide);
        end
        ticks_inc = (quiet_ticks_reg == QUIET_MAX) ? quiet_ticks_reg
                                                   : quiet_ticks_reg + QUIET_BITS'(1);
        rise   = (mean > reported_mean_reg) &&
                 ((mean - reported_mean_reg) > cfg.rise_threshold);
        quiet  = ticks_inc > QUIET_BITS'(cfg.quiet_limit);
        report = prod_valid_reg && (rise || quiet);
        stall  = report && out_valid_reg && !out_ready;
        decide = advance && prod_valid_reg;

        reported_mean_next = reported_mean_reg;
        quiet_ticks_next   = quiet_ticks_reg;
        mean_value_next    = mean_value_reg;
        forced_next        = forced_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        if (decide)
        begin
            quiet_ticks_next = ticks_inc;
            if (report)
            begin
                reported_mean_next = mean;
                quiet_ticks_next   = '0;
                mean_value_next    = mean;
                forced_next        = !rise;
                out_valid_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg    <= 1'b0;
            reported_mean_reg <= '0;
            quiet_ticks_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            prod_valid_reg    <= prod_valid_next;
            reported_mean_reg <= reported_mean_next;
            quiet_ticks_reg   <= quiet_ticks_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        mean_value_reg <= mean_value_next;
        forced_reg     <= forced_next;
    end

    assign out_valid     = out_valid_reg;
    assign mean_value    = mean_value_reg;
    assign forced_report = forced_reg;

    `MAR_ASSERT_NEXT(a_report_clears_quiet, decide && report, quiet_ticks_reg == '0)
    `MAR_ASSERT_NEXT(a_report_loads_output, decide && report,
                     out_valid_reg && (mean_value_reg == reported_mean_reg))
    `MAR_ASSERT_NEXT(a_mean_held_without_report, !(decide && report),
                     $stable(reported_mean_reg))

endmodule

// ----- rtl/core/moving_average_rise_reporter_unit.sv -----
// top level of the moving average rise reporter
`timescale 1ns / 1ps

// moving average rise reporter: each input transaction carries one converter
// sample, which enters a shift chain of WINDOW sample cells (all zero after
// reset, so zeros count until the window has filled). a running sum of the
// window feeds a reciprocal multiply that gives floor(sum * 256 / WINDOW),
// the mean in raw counts with 8 fraction bits, saturated to 20 bits. a result
// transaction is sent when the mean rises above the last reported mean by
// more than rise_threshold (forced_report = 0), or when the count of samples
// since the last report passes quiet_limit (forced_report = 1); a rise wins
// when both hold. one sample is taken every clock cycle unless the input
// stalls; the sum register is loaded at the edge that accepts the sample,
// then the product register and then the output register, each as the
// pipeline advances. the output register lets samples keep flowing while a
// result waits; the input stalls only when a sample that reports reaches
// the decision stage while the previous result is still untaken.
// configuration must be written through cfg_write / cfg_index / cfg_data
// only while the block is idle; the block itself does not enforce this
module moving_average_rise_reporter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mar_pkg::ADC_BITS-1:0]       adc_sample,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mar_pkg::MEAN_BITS-1:0]      mean_value,
    output logic                               forced_report,
    // configuration write port
    input  logic                               cfg_write,
    input  logic [mar_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mar_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import mar_pkg::*;

    mar_cfg_t               cfg_reg;
    mar_cfg_t               cfg_next;
    logic                   stall;
    logic                   advance;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SUM_BITS-1:0]    total;
    logic                   total_valid;

    // configuration registers, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RISE_THRESHOLD: cfg_next.rise_threshold = THRESH_BITS'(cfg_data);
                REG_QUIET_LIMIT:    cfg_next.quiet_limit    = LIMIT_BITS'(cfg_data);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_threshold <= RISE_THRESHOLD_RESET;
            cfg_reg.quiet_limit    <= QUIET_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // the whole pipeline moves together unless a report is blocked at the output
    assign advance  = !stall;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    // sample cast to SAMPLE_BITS; ADC_BITS is the same width, so no bits are dropped
    assign sample = SAMPLE_BITS'(adc_sample);

    mar_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .accept      (accept),
        .sample      (sample),
        .total       (total),
        .total_valid (total_valid)
    );

    mar_report u_report (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cfg           (cfg_reg),
        .total         (total),
        .total_valid   (total_valid),
        .stall         (stall),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean_value    (mean_value),
        .forced_report (forced_report)
    );

endmodule
